FILE: rtl/core/igp_pkg.sv
// ----------------------------------------------------------------------------
// igp_pkg
// Shared types and constants of the im2col patch gather unit.
// ----------------------------------------------------------------------------
package igp_pkg;

   // field widths
   localparam int OP_W        = 1;
   localparam int PIX_ADDR_W  = 14;
   localparam int WORD_W      = 32;
   localparam int COORD_W     = 8;
   localparam int DIM_W       = 9;
   localparam int SMALL_W     = 4;
   localparam int TAP_IDX_W   = 6;

   // control register port
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ROWS      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_COLS      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_ROWS   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_COLS   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DILATION_ROWS = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DILATION_COLS = 4'd7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PATCH = 1'b1;

   // signed tap position: -15 .. 3930
   localparam int POS_W     = 13;
   // signed channel*height + base row: -15 .. 134130
   localparam int ROWSUM_W  = 19;
   // biased linear address before reduction
   localparam int LIN_W     = 28;
   // bias floor, above the magnitude of the most negative linear address
   localparam int LIN_BIAS_MIN = 8192;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [PIX_ADDR_W-1:0] pixel_addr;
      logic [WORD_W-1:0]     pixel_value;
      logic [COORD_W-1:0]    channel;
      logic [COORD_W-1:0]    out_row;
      logic [COORD_W-1:0]    out_col;
   } igp_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]    tap_value;
      logic                 is_pad;
      logic [TAP_IDX_W-1:0] tap_index;
      logic                 last;
   } igp_rsp_type;

endpackage

FILE: rtl/core/igp_mod_reduce.sv
// ----------------------------------------------------------------------------
// igp_mod_reduce
// Three-stage pipelined reduction of an unsigned value modulo DEPTH,
// by reciprocal multiply, quotient back-multiply and a final correction.
// ----------------------------------------------------------------------------
module igp_mod_reduce #(
   parameter int DEPTH = 16384,
   parameter int IN_W  = 28
) (
   input  logic                      clock,
   input  logic [IN_W-1:0]           x_in,
   output logic [$clog2(DEPTH)-1:0]  rem
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SHIFT  = IN_W + ADDR_W;
   localparam int PROD_W = 2 * IN_W + 1;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
   localparam logic [IN_W:0]   RECIP   = RECIP_WIDE[IN_W:0];
   localparam logic [IN_W-1:0] DEPTH_V = IN_W'(DEPTH);

   logic [IN_W-1:0]   x1_ff;
   logic [PROD_W-1:0] prod1_ff;
   logic [IN_W-1:0]   x2_ff;
   logic [IN_W-1:0]   qd2_ff;
   logic [ADDR_W-1:0] rem_ff;

   logic [IN_W-1:0]   quot;
   logic [IN_W-1:0]   diff;
   logic [IN_W-1:0]   fixed;

   always_comb begin
      quot  = IN_W'(prod1_ff >> SHIFT);
      diff  = x2_ff - qd2_ff;
      fixed = (diff >= DEPTH_V) ? (diff - DEPTH_V) : diff;
   end

   always_ff @(posedge clock) begin
      x1_ff    <= x_in;
      prod1_ff <= PROD_W'(x_in) * PROD_W'(RECIP);
      x2_ff    <= x1_ff;
      qd2_ff   <= IN_W'(quot * DEPTH_V);
      rem_ff   <= fixed[ADDR_W-1:0];
   end

   assign rem = rem_ff;

endmodule

FILE: rtl/core/im2col_patch_gather_unit.sv
// ----------------------------------------------------------------------------
// im2col_patch_gather_unit
// Image store plus im2col patch walker with padding, stride and dilation.
// ----------------------------------------------------------------------------
// A write transfer (op 0) stores one 32-bit pixel word at pixel_addr modulo
// STORE_DEPTH; writes are taken one per cycle while the unit is idle and give
// no response. A patch transfer (op 1) names a channel and an output position;
// the unit answers with WIN_ROWS*WIN_COLS response transfers in row-major tap
// order, each the stored word (or zero with is_pad set when the tap falls
// outside the image), its tap number, and last on the final tap. A patch
// request holds off the input side through address setup in the shared modulo
// pipeline, then one store read per tap on the single read port; taps wait
// while the response queue has no room. A two-entry response queue lets the
// next request or write be taken while earlier responses still wait. Reading
// a store word that was never written returns an unspecified value. Control
// registers are to be written only while the unit is idle; the unit does not
// enforce this, and csr_ready is always high.
// ----------------------------------------------------------------------------
module im2col_patch_gather_unit #(
   parameter int WIN_ROWS    = 3,
   parameter int WIN_COLS    = 3,
   parameter int STORE_DEPTH = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  igp_pkg::igp_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output igp_pkg::igp_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [igp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [igp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import igp_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int J_W    = (WIN_COLS > 1) ? $clog2(WIN_COLS) : 1;
   localparam logic [TAP_IDX_W-1:0] LAST_IDX = TAP_IDX_W'(WIN_ROWS * WIN_COLS - 1);
   localparam logic [J_W-1:0]       LAST_COL = J_W'(WIN_COLS - 1);
   localparam logic [ADDR_W:0]      DEPTH_X  = (ADDR_W + 1)'(STORE_DEPTH);
   // multiple of the depth that lifts every linear address above zero
   localparam int LIN_BIAS =
      STORE_DEPTH * ((LIN_BIAS_MIN + STORE_DEPTH - 1) / STORE_DEPTH);
   localparam logic signed [LIN_W:0] LIN_BIAS_V = (LIN_W + 1)'(LIN_BIAS);

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;  // take writes and requests
   localparam logic [3:0] ST_MUL  = 4'd1;  // base row/col, chan*height, row step
   localparam logic [3:0] ST_ROW  = 4'd2;  // chan*height + base row; reduce row step
   localparam logic [3:0] ST_LIN  = 4'd3;  // biased linear address of tap 0
   localparam logic [3:0] ST_RED  = 4'd4;  // reduce linear address
   localparam logic [3:0] ST_STEP = 4'd5;  // row step lands
   localparam logic [3:0] ST_WAIT = 4'd6;
   localparam logic [3:0] ST_BASE = 4'd7;  // tap 0 address lands
   localparam logic [3:0] ST_TAP  = 4'd8;  // one store read per tap

   // control registers
   logic [DIM_W-1:0]   image_height_ff, image_width_ff;
   logic [SMALL_W-1:0] pad_rows_ff, pad_cols_ff;
   logic [SMALL_W-1:0] stride_rows_ff, stride_cols_ff;
   logic [SMALL_W-1:0] dilation_rows_ff, dilation_cols_ff;

   logic [3:0] state_ff, state_in;

   // latched request
   logic [COORD_W-1:0] chan_ff, orow_ff, ocol_ff;

   // setup pipeline
   logic signed [POS_W-1:0]    base_row_ff, base_col_ff;
   logic signed [POS_W-1:0]    base_row_in, base_col_in;
   logic [16:0]                ch_h_ff;
   logic [12:0]                drw_ff;
   logic signed [ROWSUM_W-1:0] rowsum_ff, rowsum_in;
   logic [LIN_W-1:0]           x_lin_ff;
   logic signed [LIN_W:0]      lin_calc;
   logic [11:0]                row_prod, col_prod;
   logic [ADDR_W-1:0]          row_step_ff;

   // modulo pipeline
   logic [LIN_W-1:0]  red_x;
   logic [ADDR_W-1:0] red_rem;

   // pixel writes ride alongside the modulo pipeline
   logic [2:0]        wr_vld_ff;
   logic [WORD_W-1:0] wr_word_ff [3];

   // tap walker
   logic signed [POS_W-1:0] row_ff, col_ff;
   logic [J_W-1:0]          col_idx_ff;
   logic [TAP_IDX_W-1:0]    tap_idx_ff;
   logic [ADDR_W-1:0]       row_addr_ff, tap_addr_ff;
   logic [ADDR_W-1:0]       row_addr_nx, tap_addr_cn;
   logic                    tap_in_img;
   logic                    tap_issue;
   logic [2:0]              queue_occ;

   // store and read stage
   logic [WORD_W-1:0]    store_mem [STORE_DEPTH];
   logic [WORD_W-1:0]    rd_word_ff;
   logic                 rd_vld_ff;
   logic                 rd_pad_ff;
   logic [TAP_IDX_W-1:0] rd_idx_ff;
   logic                 rd_last_ff;

   // response queue
   igp_rsp_type fifo_ff [2];
   igp_rsp_type push_entry;
   logic        fifo_wr_ff, fifo_rd_ff;
   logic [1:0]  fifo_cnt_ff;
   logic        rsp_pop;
   logic        req_take;

   function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_X) begin
         s = s - DEPTH_X;
      end
      return s[ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------- ports
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = (fifo_cnt_ff != 2'd0);
   assign rsp_data  = fifo_ff[fifo_rd_ff];
   assign rsp_pop   = rsp_valid && !rsp_stall;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff  <= DIM_W'(1);
         image_width_ff   <= DIM_W'(1);
         pad_rows_ff      <= '0;
         pad_cols_ff      <= '0;
         stride_rows_ff   <= SMALL_W'(1);
         stride_cols_ff   <= SMALL_W'(1);
         dilation_rows_ff <= SMALL_W'(1);
         dilation_cols_ff <= SMALL_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            CSR_PAD_ROWS:      pad_rows_ff      <= csr_wdata[SMALL_W-1:0];
            CSR_PAD_COLS:      pad_cols_ff      <= csr_wdata[SMALL_W-1:0];
            CSR_STRIDE_ROWS:   stride_rows_ff   <= csr_wdata[SMALL_W-1:0];
            CSR_STRIDE_COLS:   stride_cols_ff   <= csr_wdata[SMALL_W-1:0];
            CSR_DILATION_ROWS: dilation_rows_ff <= csr_wdata[SMALL_W-1:0];
            CSR_DILATION_COLS: dilation_cols_ff <= csr_wdata[SMALL_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- setup math
   always_comb begin
      row_prod    = 12'(orow_ff) * 12'(stride_rows_ff);
      col_prod    = 12'(ocol_ff) * 12'(stride_cols_ff);
      base_row_in = $signed({1'b0, row_prod}) - $signed({9'd0, pad_rows_ff});
      base_col_in = $signed({1'b0, col_prod}) - $signed({9'd0, pad_cols_ff});
      rowsum_in   = $signed({2'b00, ch_h_ff})
                  + $signed({{(ROWSUM_W - POS_W){base_row_ff[POS_W-1]}}, base_row_ff});
      lin_calc    = (LIN_W + 1)'(rowsum_ff)
                  * $signed({{(LIN_W + 1 - DIM_W){1'b0}}, image_width_ff})
                  + (LIN_W + 1)'(base_col_ff)
                  + LIN_BIAS_V;
   end

   // shared modulo pipeline: write addresses in idle, row step and tap 0 in setup
   always_comb begin
      case (state_ff)
         ST_ROW:  red_x = LIN_W'(drw_ff);
         ST_RED:  red_x = x_lin_ff;
         default: red_x = LIN_W'(req_data.pixel_addr);
      endcase
   end

   igp_mod_reduce #(
      .DEPTH (STORE_DEPTH),
      .IN_W  (LIN_W)
   ) u_reduce (
      .clock (clock),
      .x_in  (red_x),
      .rem   (red_rem)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         chan_ff <= req_data.channel;
         orow_ff <= req_data.out_row;
         ocol_ff <= req_data.out_col;
      end
      if (state_ff == ST_MUL) begin
         base_row_ff <= base_row_in;
         base_col_ff <= base_col_in;
         ch_h_ff     <= 17'(chan_ff) * 17'(image_height_ff);
         drw_ff      <= 13'(dilation_rows_ff) * 13'(image_width_ff);
      end
      if (state_ff == ST_ROW) begin
         rowsum_ff <= rowsum_in;
      end
      if (state_ff == ST_LIN) begin
         x_lin_ff <= lin_calc[LIN_W-1:0];
      end
      if (state_ff == ST_STEP) begin
         row_step_ff <= red_rem;
      end
   end

   // ---------------------------------------------------------------- write pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= '0;
      end else begin
         wr_vld_ff <= {wr_vld_ff[1:0], req_take && (req_data.op == OP_WRITE)};
      end
   end

   always_ff @(posedge clock) begin
      wr_word_ff[0] <= req_data.pixel_value;
      wr_word_ff[1] <= wr_word_ff[0];
      wr_word_ff[2] <= wr_word_ff[1];
   end

   // ---------------------------------------------------------------- tap walker
   always_comb begin
      tap_in_img = !row_ff[POS_W-1]
                && (row_ff[POS_W-2:0] < (POS_W - 1)'(image_height_ff))
                && !col_ff[POS_W-1]
                && (col_ff[POS_W-2:0] < (POS_W - 1)'(image_width_ff));
      // room check: queue entries plus the read in flight, less this pop
      queue_occ   = 3'(fifo_cnt_ff) + 3'(rd_vld_ff) - 3'(rsp_pop);
      tap_issue   = (state_ff == ST_TAP) && (queue_occ <= 3'd1);
      row_addr_nx = mod_add(row_addr_ff, row_step_ff);
      tap_addr_cn = mod_add(tap_addr_ff, ADDR_W'(dilation_cols_ff));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_BASE) begin
         row_ff      <= base_row_ff;
         col_ff      <= base_col_ff;
         col_idx_ff  <= '0;
         tap_idx_ff  <= '0;
         row_addr_ff <= red_rem;
         tap_addr_ff <= red_rem;
      end else if (tap_issue) begin
         tap_idx_ff <= tap_idx_ff + TAP_IDX_W'(1);
         if (col_idx_ff == LAST_COL) begin
            col_idx_ff  <= '0;
            row_ff      <= row_ff + $signed({{(POS_W - SMALL_W){1'b0}}, dilation_rows_ff});
            col_ff      <= base_col_ff;
            row_addr_ff <= row_addr_nx;
            tap_addr_ff <= row_addr_nx;
         end else begin
            col_idx_ff  <= col_idx_ff + J_W'(1);
            col_ff      <= col_ff + $signed({{(POS_W - SMALL_W){1'b0}}, dilation_cols_ff});
            tap_addr_ff <= tap_addr_cn;
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take && (req_data.op == OP_PATCH)) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ROW;
         ST_ROW:  state_in = ST_LIN;
         ST_LIN:  state_in = ST_RED;
         ST_RED:  state_in = ST_STEP;
         ST_STEP: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_BASE;
         ST_BASE: state_in = ST_TAP;
         ST_TAP:  if (tap_issue && (tap_idx_ff == LAST_IDX)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- store
   always_ff @(posedge clock) begin
      if (wr_vld_ff[2]) begin
         store_mem[red_rem] <= wr_word_ff[2];
      end
      if (tap_issue && tap_in_img) begin
         rd_word_ff <= store_mem[tap_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= tap_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (tap_issue) begin
         rd_pad_ff  <= !tap_in_img;
         rd_idx_ff  <= tap_idx_ff;
         rd_last_ff <= (tap_idx_ff == LAST_IDX);
      end
   end

   // ---------------------------------------------------------------- response queue
   always_comb begin
      push_entry.tap_value = rd_pad_ff ? '0 : rd_word_ff;
      push_entry.is_pad    = rd_pad_ff;
      push_entry.tap_index = rd_idx_ff;
      push_entry.last      = rd_last_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         fifo_ff[fifo_wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff  <= 1'b0;
         fifo_rd_ff  <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         if (rd_vld_ff) fifo_wr_ff <= !fifo_wr_ff;
         if (rsp_pop)   fifo_rd_ff <= !fifo_rd_ff;
         fifo_cnt_ff <= fifo_cnt_ff + 2'(rd_vld_ff) - 2'(rsp_pop);
      end
   end

   // ---------------------------------------------------------------- checks
   a_last_tap_ends: assert property (@(posedge clock) disable iff (reset)
      (tap_issue && (tap_idx_ff == LAST_IDX)) |=> (state_ff == ST_IDLE))
      else $error("patch walk did not end after the last tap");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && (fifo_cnt_ff == 2'd2)) |-> rsp_pop)
      else $error("read landed on a full response queue");

   a_tap_addr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAP) |-> ({1'b0, tap_addr_ff} < DEPTH_X))
      else $error("tap address beyond store depth");

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      wr_vld_ff[2] |-> ({1'b0, red_rem} < DEPTH_X))
      else $error("write address beyond store depth");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.tap_index == LAST_IDX)))
      else $error("last flag does not match tap number");

endmodule

FILE: tb/sv/im2col_patch_gather_unit_tb.sv
// ----------------------------------------------------------------------------
// im2col_patch_gather_unit_tb
// Self-checking testbench of the im2col patch gather unit.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the image store and the layout registers.
// From every accepted transfer it works out the tap words, pad flags, tap
// numbers and last markers that the unit has to return, and checks each
// response transfer against the oldest one still owed. A directed opening
// covers the corners of the fields and the layout registers (zero sizes and
// largest pad, stride and dilation), then randomized phases run under several
// layouts (out-of-range sizes among them), random request gaps, response stalls.
// Before a patch request, any store word that one of its taps would read and
// that was never written is written first, so no unwritten word is ever read.
// ----------------------------------------------------------------------------
module im2col_patch_gather_unit_tb;

   import igp_pkg::*;

   localparam int WIN_ROWS_C    = 3;
   localparam int WIN_COLS_C    = 3;
   localparam int STORE_DEPTH_C = 16384;
   // allow well past the time a patch holds the input side
   localparam int DRAIN_CYCLES  = 40;
   localparam int LONG_HOLD     = 300;
   // request transfers per randomized phase, fill writes included
   localparam int PHASE_ITEMS   = 30;
   localparam int CYCLE_LIMIT   = 500000;

   // one set of layout register values, as written on the csr port
   typedef struct {
      logic [CSR_DATA_W-1:0] height;
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] pad_r;
      logic [CSR_DATA_W-1:0] pad_c;
      logic [CSR_DATA_W-1:0] stride_r;
      logic [CSR_DATA_W-1:0] stride_c;
      logic [CSR_DATA_W-1:0] dil_r;
      logic [CSR_DATA_W-1:0] dil_c;
   } layout_type;

   // -------------------------------------------------------------------------
   // Tap predictor: image store, layout registers and the queue of taps owed
   // -------------------------------------------------------------------------
   class patch_predictor_type;
      logic [WORD_W-1:0]  pixel_mem [STORE_DEPTH_C];
      bit                 written [STORE_DEPTH_C];
      logic [DIM_W-1:0]   image_height  = 1;
      logic [DIM_W-1:0]   image_width   = 1;
      logic [SMALL_W-1:0] pad_rows      = 0;
      logic [SMALL_W-1:0] pad_cols      = 0;
      logic [SMALL_W-1:0] stride_rows   = 1;
      logic [SMALL_W-1:0] stride_cols   = 1;
      logic [SMALL_W-1:0] dilation_rows = 1;
      logic [SMALL_W-1:0] dilation_cols = 1;
      igp_rsp_type        pending_taps [$];
      int                 mismatches = 0;

      // 4-bit registers keep the low bits; unknown indexes are dropped
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_HEIGHT:  image_height  = data;
            CSR_IMAGE_WIDTH:   image_width   = data;
            CSR_PAD_ROWS:      pad_rows      = data[SMALL_W-1:0];
            CSR_PAD_COLS:      pad_cols      = data[SMALL_W-1:0];
            CSR_STRIDE_ROWS:   stride_rows   = data[SMALL_W-1:0];
            CSR_STRIDE_COLS:   stride_cols   = data[SMALL_W-1:0];
            CSR_DILATION_ROWS: dilation_rows = data[SMALL_W-1:0];
            CSR_DILATION_COLS: dilation_cols = data[SMALL_W-1:0];
            default: ;
         endcase
      endfunction

      // store address read by tap (i, j); returns 0 for a padded tap
      function bit tap_addr(igp_req_type item, int i, int j, output int addr);
         int r;
         int c;
         r = int'(item.out_row) * int'(stride_rows) - int'(pad_rows)
             + i * int'(dilation_rows);
         c = int'(item.out_col) * int'(stride_cols) - int'(pad_cols)
             + j * int'(dilation_cols);
         addr = 0;
         if (r < 0 || c < 0 || r >= int'(image_height) || c >= int'(image_width))
            return 1'b0;
         addr = ((int'(item.channel) * int'(image_height) + r) * int'(image_width) + c)
                % STORE_DEPTH_C;
         return 1'b1;
      endfunction

      // store words a patch would read that were never written
      function void unwritten_taps(igp_req_type item, output int addrs [$]);
         int addr;
         addrs = {};
         for (int i = 0; i < WIN_ROWS_C; i++)
            for (int j = 0; j < WIN_COLS_C; j++)
               if (tap_addr(item, i, j, addr) && !written[addr])
                  addrs.push_back(addr);
      endfunction

      // accepted request transfer: update the store or queue the taps owed
      function void note_transfer(igp_req_type item);
         igp_rsp_type tap;
         int          addr;
         bit          inside_img;
         if (item.op == OP_WRITE) begin
            pixel_mem[item.pixel_addr] = item.pixel_value;
            written[item.pixel_addr]   = 1'b1;
            return;
         end
         for (int i = 0; i < WIN_ROWS_C; i++) begin
            for (int j = 0; j < WIN_COLS_C; j++) begin
               inside_img    = tap_addr(item, i, j, addr);
               tap.tap_value = inside_img ? pixel_mem[addr] : '0;
               tap.is_pad    = !inside_img;
               tap.tap_index = TAP_IDX_W'(i * WIN_COLS_C + j);
               tap.last      = (i == WIN_ROWS_C - 1) && (j == WIN_COLS_C - 1);
               pending_taps.push_back(tap);
            end
         end
      endfunction

      // accepted response transfer against the oldest tap owed
      function void check_tap(igp_rsp_type got);
         igp_rsp_type want;
         if (pending_taps.size() == 0) begin
            $display("%0t: response expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_taps.pop_front();
         if (got.tap_value !== want.tap_value) begin
            $display("%0t: tap_value expected %h actual %h", $time, want.tap_value,
                     got.tap_value);
            mismatches++;
         end
         if (got.is_pad !== want.is_pad) begin
            $display("%0t: is_pad expected %b actual %b", $time, want.is_pad, got.is_pad);
            mismatches++;
         end
         if (got.tap_index !== want.tap_index) begin
            $display("%0t: tap_index expected %0d actual %0d", $time, want.tap_index,
                     got.tap_index);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   igp_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   igp_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   patch_predictor_type gather = new;

   // no-gap mode for one phase; long response hold-offs asked and served
   bit          burst       = 1'b0;
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          items_sent  = 0;
   int unsigned cycle_count = 0;

   always #1 clock = ~clock;

   im2col_patch_gather_unit #(
      .WIN_ROWS    (WIN_ROWS_C),
      .WIN_COLS    (WIN_COLS_C),
      .STORE_DEPTH (STORE_DEPTH_C)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Watchdog: a hang anywhere ends the run as a failure
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: a transfer is valid high with stall low at the edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         gather.check_tap(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Response side: runs of no stall, random stall and solid stall; a long
   // hold-off when the stimulus asks, so the response queue fills and the
   // unit pushes back on the request side
   // -------------------------------------------------------------------------
   initial begin : receiver
      int run;
      int pattern;
      @(posedge clock);
      forever begin
         if (hold_served != hold_asked) begin
            hold_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            pattern = $urandom_range(0, 9);
            run     = $urandom_range(5, 40);
            repeat (run) begin
               rsp_stall <= (pattern == 9) || (pattern >= 3 && $urandom_range(0, 2) == 0);
               @(posedge clock);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // mostly back to back, sometimes a short gap, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (burst || roll < 12)
         return 0;
      if (roll < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // pixel words lean toward all zeros and all ones
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // output position that mostly lands the window on the image
   function automatic logic [COORD_W-1:0] pick_coord(int extent, int pad, int stride);
      int lim;
      lim = (stride == 0) ? 255 : (extent + pad) / stride;
      if (lim > 255)
         lim = 255;
      if ($urandom_range(0, 3) != 0)
         return COORD_W'($urandom_range(0, lim));
      return COORD_W'($urandom_range(0, 255));
   endfunction

   // all fields random; unused fields of a transfer still toggle
   function automatic igp_req_type random_item();
      igp_req_type item;
      item.op          = OP_W'($urandom_range(0, 1));
      item.pixel_addr  = PIX_ADDR_W'($urandom_range(0, STORE_DEPTH_C - 1));
      item.pixel_value = $urandom;
      item.channel     = COORD_W'($urandom_range(0, 255));
      item.out_row     = COORD_W'($urandom_range(0, 255));
      item.out_col     = COORD_W'($urandom_range(0, 255));
      return item;
   endfunction

   // one request transfer; valid stays high into the next item when no gap
   task automatic send_item(input igp_req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      gather.note_transfer(item);
      items_sent++;
   endtask

   task automatic send_write(input logic [PIX_ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] value);
      igp_req_type item;
      item             = random_item();
      item.op          = OP_WRITE;
      item.pixel_addr  = addr;
      item.pixel_value = value;
      send_item(item);
   endtask

   // fills any unwritten word the patch would read, then sends the request
   task automatic send_patch(input logic [COORD_W-1:0] chan,
                             input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col);
      igp_req_type item;
      int          missing [$];
      item         = random_item();
      item.op      = OP_PATCH;
      item.channel = chan;
      item.out_row = row;
      item.out_col = col;
      gather.unwritten_taps(item, missing);
      foreach (missing[k])
         send_write(PIX_ADDR_W'(missing[k]), pick_word());
      send_item(item);
   endtask

   // request side quiet, every tap returned, the last write retired
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (gather.pending_taps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      gather.write_reg(idx, data);
   endtask

   // full register set, plus one write to an index past the last register
   task automatic configure(input layout_type s);
      wait_idle();
      write_reg(CSR_IMAGE_HEIGHT, s.height);
      write_reg(CSR_IMAGE_WIDTH, s.width);
      write_reg(CSR_PAD_ROWS, s.pad_r);
      write_reg(CSR_PAD_COLS, s.pad_c);
      write_reg(CSR_STRIDE_ROWS, s.stride_r);
      write_reg(CSR_STRIDE_COLS, s.stride_c);
      write_reg(CSR_DILATION_ROWS, s.dil_r);
      write_reg(CSR_DILATION_COLS, s.dil_c);
      write_reg(CSR_DILATION_COLS + CSR_IDX_W'($urandom_range(1, 8)),
                CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // 40% writes (half of them inside the current image), 60% patches
   task automatic random_step();
      int                 roll;
      int                 addr;
      int                 h;
      int                 w;
      logic [COORD_W-1:0] chan;
      h    = int'(gather.image_height);
      w    = int'(gather.image_width);
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         if (roll < 2 && h != 0 && w != 0)
            addr = (($urandom_range(0, 3) * h + $urandom_range(0, h - 1)) * w
                    + $urandom_range(0, w - 1)) % STORE_DEPTH_C;
         else
            addr = $urandom_range(0, STORE_DEPTH_C - 1);
         send_write(PIX_ADDR_W'(addr), pick_word());
      end else begin
         chan = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, 3))
                                           : COORD_W'($urandom_range(0, 255));
         send_patch(chan,
                    pick_coord(h, int'(gather.pad_rows), int'(gather.stride_rows)),
                    pick_coord(w, int'(gather.pad_cols), int'(gather.stride_cols)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      layout_type phases [6];
      int         phase_stop;

      // typical same-size window, no gaps at all
      phases[0] = '{9'd5, 9'd6, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd1};
      // mixed strides and dilations, with a long response hold-off
      phases[1] = '{9'd16, 9'd16, 9'd2, 9'd0, 9'd2, 9'd1, 9'd2, 9'd3};
      // sizes past the range; junk in the upper bits of the 4-bit registers
      phases[2] = '{9'h1FF, 9'h1FF, 9'h1F3, 9'h120, 9'h101, 9'h1F2, 9'h0F1, 9'h042};
      // smallest image, again under a long hold-off
      phases[3] = '{9'd1, 9'd1, 9'd0, 9'd0, 9'd1, 9'd1, 9'd1, 9'd1};
      // phases[4] is drawn at random below
      // zero stride and zero dilation on the rows: all taps share one row
      phases[5] = '{9'd3, 9'd7, 9'd1, 9'd2, 9'd0, 9'd3, 9'd0, 9'd1};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset layout (1x1, no pad, unit stride and dilation)
      send_write(14'd0, 32'hFFFF_FFFF);
      send_write(14'h3FFF, 32'h0000_0000);
      send_write(14'h2AAA, 32'h5555_5555);
      send_patch(8'd0, 8'd0, 8'd0);
      send_patch(8'd255, 8'd0, 8'd0);
      send_patch(8'd0, 8'd255, 8'd255);
      send_patch(8'd0, 8'd0, 8'd1);

      // directed: 256x256 image, largest pads, strides and dilations
      configure('{9'd256, 9'd256, 9'd15, 9'd15, 9'd15, 9'd15, 9'd15, 9'd15});
      send_patch(8'd0, 8'd0, 8'd0);       // first-row and first-column taps padded, rest read
      send_patch(8'd255, 8'd255, 8'd255); // window far past the image
      send_patch(8'd255, 8'd1, 8'd1);     // last channel, address wraps

      // directed: zero height and width, zero stride and dilation
      configure('{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0});
      send_patch(8'd7, 8'd3, 8'd4);

      for (int p = 0; p < 6; p++) begin
         if (p == 4)
            phases[4] = '{CSR_DATA_W'($urandom_range(0, 24)),
                          CSR_DATA_W'($urandom_range(0, 24)),
                          CSR_DATA_W'($urandom_range(0, 511)),
                          CSR_DATA_W'($urandom_range(0, 511)),
                          CSR_DATA_W'($urandom_range(0, 511)),
                          CSR_DATA_W'($urandom_range(0, 511)),
                          CSR_DATA_W'($urandom_range(0, 511)),
                          CSR_DATA_W'($urandom_range(0, 511))};
         configure(phases[p]);
         burst = (p == 0);
         if (p == 1 || p == 3)
            hold_asked++;
         phase_stop = items_sent + PHASE_ITEMS;
         while (items_sent < phase_stop)
            random_step();
      end

      wait_idle();
      if (gather.mismatches == 0 && gather.pending_taps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
